>>> hw/rtl/averaged_current_monitor_macros.svh
// assertion macros shared by the monitor rtl
`ifndef AVERAGED_CURRENT_MONITOR_MACROS_SVH
`define AVERAGED_CURRENT_MONITOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ACM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("monitor check failed");

// condition never holds
`define ACM_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("monitor check failed");

`endif

>>> hw/rtl/acm_pkg.sv
`default_nettype none

package acm_pkg;

   localparam int unsigned AdcWidth       = 12;
   localparam int unsigned MvWidth        = 12;
   localparam int unsigned SumWidth       = 16;
   localparam int unsigned CurrentWidth   = 16;
   localparam int unsigned ThresholdWidth = 16;

   // millivolt scaling, 3300/4095 reduced to 220/273
   localparam int unsigned MvFullScale   = 3300;
   localparam int unsigned AdcFullCode   = 4095;
   localparam int unsigned MvGcd         = 15;
   localparam int unsigned MvNum         = MvFullScale / MvGcd;
   localparam int unsigned MvDen         = AdcFullCode / MvGcd;
   localparam int unsigned ScaledWidth   = AdcWidth + 8;
   localparam int unsigned MvRecipShift  = 24;
   localparam int unsigned MvRecipWidth  = 16;
   localparam int unsigned MvRecip       = (1 << MvRecipShift) / MvDen;
   localparam int unsigned MvProdWidth   = ScaledWidth + MvRecipWidth;

   // group average divide
   localparam int unsigned DivRecipShift = 20;
   localparam int unsigned DivRecipWidth = DivRecipShift + 1;
   localparam int unsigned DivProdWidth  = SumWidth + DivRecipWidth;
   localparam int unsigned AvgMax        = 4095;

   // current conversion
   localparam int unsigned MaPerMvNum    = 10000;
   localparam int unsigned MaPerMvDen    = 125;
   localparam int unsigned MaPerMv       = MaPerMvNum / MaPerMvDen;
   localparam int unsigned CurFullWidth  = MvWidth + 7;
   localparam int unsigned CurrentMax    = 65535;
   localparam int unsigned DeadbandMa    = 500;

   // group sum queue
   localparam int unsigned QueueDepth    = 4;
   localparam int unsigned QueuePtrWidth = 2;

   // register port
   localparam int unsigned CsrAddrWidth      = 3;
   localparam int unsigned CsrDataWidth      = 32;
   localparam int unsigned CsrIndexWidth     = CsrAddrWidth - 2;
   localparam int unsigned CsrThresholdIndex = 0;
   localparam int unsigned ThresholdReset    = 3000;

   // stream widths
   localparam int unsigned ReqDataWidth = 16;
   localparam int unsigned RspDataWidth = 48;
   localparam int unsigned RspUsedWidth = CurrentWidth + 1 + MvWidth + MvWidth;

   typedef struct packed {
      logic                valid;
      logic [SumWidth-1:0] sum;
   } acm_sum_req_type;

endpackage

`default_nettype wire

>>> hw/rtl/averaged_current_monitor.sv
`default_nettype none
`include "averaged_current_monitor_macros.svh"

// Averaged current monitor. Takes one 12-bit sensor sample per clock on the
// req stream, scales it to millivolts and sums groups of SAMPLES_PER_RESULT
// samples. Each finished group gives one response: the group average in mV,
// the zero reference in use (captured from the first group whose average is
// nonzero), the deviation current in mA (times 80, saturated at 65535, zero
// below 500) and an over-limit flag against the threshold register at byte
// address 0 (reset 3000). Samples are taken back to back at one per clock
// while req_tready is high; a group's sum passes the four-stage scaling pipe,
// the group-sum queue and the five-stage averaging pipe before rsp_tvalid
// rises. The four-entry queue of group sums lets sampling run on while the
// response side is held; when it fills, req_tready drops while the sample
// that closes the next group waits at the end of the scaling pipe. No
// clearing pass after reset.
module averaged_current_monitor #(
   parameter int unsigned SAMPLES_PER_RESULT = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // adc_sample [11:0]
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [acm_pkg::ReqDataWidth-1:0]  req_tdata,
   // current_ma [15:0], over_limit [16], average_mv [28:17], reference_mv [40:29]
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [acm_pkg::RspDataWidth-1:0]       rsp_tdata,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [acm_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  wire logic [acm_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [acm_pkg::CsrDataWidth-1:0]       csr_prdata,
   output logic                                   csr_pready
);

   logic [acm_pkg::ThresholdWidth-1:0] threshold_ff, threshold_in;
   logic [acm_pkg::CsrIndexWidth-1:0]  csr_index;
   logic                               csr_write;
   acm_pkg::acm_sum_req_type           queue_push;
   acm_pkg::acm_sum_req_type           queue_head;
   logic                               queue_full;
   logic                               queue_pop;
   logic [acm_pkg::CurrentWidth-1:0]   rsp_current;
   logic                               rsp_over;
   logic [acm_pkg::MvWidth-1:0]        rsp_avg, rsp_ref;

   // register port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[acm_pkg::CsrAddrWidth-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_write && (csr_index == acm_pkg::CsrIndexWidth'(acm_pkg::CsrThresholdIndex))) begin
         threshold_in = csr_pwdata[acm_pkg::ThresholdWidth-1:0];
      end
      if (csr_index == acm_pkg::CsrIndexWidth'(acm_pkg::CsrThresholdIndex)) begin
         csr_prdata = acm_pkg::CsrDataWidth'(threshold_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= acm_pkg::ThresholdWidth'(acm_pkg::ThresholdReset);
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   acm_front #(
      .SAMPLES_PER_RESULT(SAMPLES_PER_RESULT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .adc_sample (req_tdata[acm_pkg::AdcWidth-1:0]),
      .push       (queue_push),
      .queue_full (queue_full)
   );

   acm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (queue_push),
      .full  (queue_full),
      .head  (queue_head),
      .pop   (queue_pop)
   );

   acm_back #(
      .SAMPLES_PER_RESULT(SAMPLES_PER_RESULT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (queue_head),
      .pop          (queue_pop),
      .threshold    (threshold_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .current_ma   (rsp_current),
      .over_limit   (rsp_over),
      .average_mv   (rsp_avg),
      .reference_mv (rsp_ref)
   );

   assign rsp_tdata = {
      (acm_pkg::RspDataWidth - acm_pkg::RspUsedWidth)'(0),
      rsp_ref, rsp_avg, rsp_over, rsp_current
   };

   // a zero reference means nothing captured yet, so the average was zero too
   `ACM_ASSERT_IMPLIES(a_ref_capture, clock, reset,
      rsp_tvalid && (rsp_ref == '0), rsp_avg == '0)
   // deadband leaves no small nonzero current
   `ACM_ASSERT_IMPLIES(a_deadband, clock, reset, rsp_tvalid && (rsp_current != '0),
      rsp_current >= acm_pkg::CurrentWidth'(acm_pkg::DeadbandMa))
   // flag agrees with the threshold in use
   `ACM_ASSERT_IMPLIES(a_over_limit, clock, reset, rsp_tvalid,
      rsp_over == (rsp_current >= threshold_ff))
   // front never hands a sum to a full queue
   `ACM_ASSERT_NEVER(a_queue_overrun, clock, reset, queue_push.valid && queue_full)

endmodule

`default_nettype wire

>>> hw/rtl/acm_front.sv
`default_nettype none

module acm_front #(
   parameter int unsigned SAMPLES_PER_RESULT = 10
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [acm_pkg::AdcWidth-1:0]    adc_sample,
   output acm_pkg::acm_sum_req_type             push,
   input  wire logic                            queue_full
);

   localparam int unsigned CountWidth =
      (SAMPLES_PER_RESULT > 1) ? $clog2(SAMPLES_PER_RESULT) : 1;
   localparam logic [CountWidth-1:0] LastCount = CountWidth'(SAMPLES_PER_RESULT - 1);

   logic                                s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [acm_pkg::ScaledWidth-1:0]     s1_scaled_ff, s1_scaled_in;
   logic [acm_pkg::ScaledWidth-1:0]     s2_scaled_ff;
   logic [acm_pkg::MvProdWidth-1:0]     s2_prod_ff, s2_prod_in;
   logic [acm_pkg::ScaledWidth-1:0]     s3_scaled_ff;
   logic [acm_pkg::MvWidth-1:0]         s3_quot_ff, s3_quot_in;
   logic [acm_pkg::ScaledWidth-1:0]     s3_qmul_ff, s3_qmul_in;
   logic [acm_pkg::MvWidth-1:0]         s4_mv_ff, s4_mv_in;
   logic [acm_pkg::ScaledWidth-1:0]     s4_rem;
   logic [acm_pkg::SumWidth-1:0]        sum_ff, sum_in, sum_next;
   logic [CountWidth-1:0]               count_ff, count_in;
   logic                                group_done;
   logic                                advance;
   logic                                accept;

   assign group_done = (count_ff == LastCount);
   assign advance    = !(s4_valid_ff && group_done && queue_full);
   assign accept     = req_valid && advance;
   assign req_ready  = advance;

   // scale to millivolts: floor(x*220/273) by reciprocal with one correction
   always_comb begin
      s1_scaled_in = acm_pkg::ScaledWidth'(adc_sample) * acm_pkg::ScaledWidth'(acm_pkg::MvNum);
      s2_prod_in   = acm_pkg::MvProdWidth'(s1_scaled_ff)
                     * acm_pkg::MvProdWidth'(acm_pkg::MvRecip);
      s3_quot_in   = s2_prod_ff[acm_pkg::MvRecipShift +: acm_pkg::MvWidth];
      s3_qmul_in   = acm_pkg::ScaledWidth'(s3_quot_in) * acm_pkg::ScaledWidth'(acm_pkg::MvDen);
      s4_rem       = s3_scaled_ff - s3_qmul_ff;
      s4_mv_in     = s3_quot_ff
                     + acm_pkg::MvWidth'(s4_rem >= acm_pkg::ScaledWidth'(acm_pkg::MvDen));
   end

   // accumulate group
   always_comb begin
      sum_next = sum_ff + acm_pkg::SumWidth'(s4_mv_ff);
      sum_in   = sum_ff;
      count_in = count_ff;
      if (s4_valid_ff && advance) begin
         if (group_done) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + CountWidth'(1);
         end
      end
   end

   assign push.valid = s4_valid_ff && group_done && advance;
   assign push.sum   = sum_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         sum_ff      <= '0;
         count_ff    <= '0;
      end else begin
         if (advance) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
         end
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_scaled_ff <= s1_scaled_in;
         s2_scaled_ff <= s1_scaled_ff;
         s2_prod_ff   <= s2_prod_in;
         s3_scaled_ff <= s2_scaled_ff;
         s3_quot_ff   <= s3_quot_in;
         s3_qmul_ff   <= s3_qmul_in;
         s4_mv_ff     <= s4_mv_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/acm_queue.sv
`default_nettype none

module acm_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire acm_pkg::acm_sum_req_type push,
   output logic                      full,
   output acm_pkg::acm_sum_req_type  head,
   input  wire logic                 pop
);

   logic [acm_pkg::SumWidth-1:0]      slots_ff [acm_pkg::QueueDepth];
   logic [acm_pkg::QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [acm_pkg::QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [acm_pkg::QueuePtrWidth:0]   count_ff, count_in;
   logic                              do_push, do_pop;

   assign full       = (count_ff == (acm_pkg::QueuePtrWidth + 1)'(acm_pkg::QueueDepth));
   assign head.valid = (count_ff != '0);
   assign head.sum   = slots_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + acm_pkg::QueuePtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + acm_pkg::QueuePtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (acm_pkg::QueuePtrWidth + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (acm_pkg::QueuePtrWidth + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.sum;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/acm_back.sv
`default_nettype none

module acm_back #(
   parameter int unsigned SAMPLES_PER_RESULT = 10
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire acm_pkg::acm_sum_req_type           head,
   output logic                                    pop,
   input  wire logic [acm_pkg::ThresholdWidth-1:0] threshold,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [acm_pkg::CurrentWidth-1:0]        current_ma,
   output logic                                    over_limit,
   output logic [acm_pkg::MvWidth-1:0]             average_mv,
   output logic [acm_pkg::MvWidth-1:0]             reference_mv
);

   localparam logic [acm_pkg::DivRecipWidth-1:0] DivRecip =
      acm_pkg::DivRecipWidth'((64'd1 << acm_pkg::DivRecipShift) / SAMPLES_PER_RESULT);
   localparam logic [acm_pkg::SumWidth-1:0] Divisor = acm_pkg::SumWidth'(SAMPLES_PER_RESULT);

   logic                                b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff;
   logic [acm_pkg::SumWidth-1:0]        b1_sum_ff;
   logic [acm_pkg::DivProdWidth-1:0]    b1_prod_ff, b1_prod_in;
   logic [acm_pkg::SumWidth-1:0]        b2_sum_ff;
   logic [acm_pkg::SumWidth-1:0]        b2_quot_ff, b2_quot_in;
   logic [acm_pkg::SumWidth-1:0]        b2_qmul_ff, b2_qmul_in;
   logic [acm_pkg::SumWidth-1:0]        b3_rem, b3_avg_full;
   logic [acm_pkg::MvWidth-1:0]         b3_avg_ff, b3_avg_in;
   logic [acm_pkg::MvWidth-1:0]         zero_ref_ff, zero_ref_in;
   logic [acm_pkg::MvWidth-1:0]         b4_avg_ff, b4_ref_ff;
   logic [acm_pkg::MvWidth-1:0]         b4_diff_ff, b4_diff_in;
   logic [acm_pkg::CurFullWidth-1:0]    cur_full;
   logic [acm_pkg::CurrentWidth-1:0]    cur_sat, cur_final;
   logic                                rsp_valid_ff;
   logic [acm_pkg::CurrentWidth-1:0]    rsp_current_ff;
   logic                                rsp_over_ff;
   logic [acm_pkg::MvWidth-1:0]         rsp_avg_ff, rsp_ref_ff;
   logic                                advance;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop     = advance && head.valid;

   // average: reciprocal multiply, then one correction step
   always_comb begin
      b1_prod_in  = acm_pkg::DivProdWidth'(head.sum) * acm_pkg::DivProdWidth'(DivRecip);
      b2_quot_in  = b1_prod_ff[acm_pkg::DivRecipShift +: acm_pkg::SumWidth];
      b2_qmul_in  = b2_quot_in * Divisor;
      b3_rem      = b2_sum_ff - b2_qmul_ff;
      b3_avg_full = b2_quot_ff + acm_pkg::SumWidth'(b3_rem >= Divisor);
      if (b3_avg_full > acm_pkg::SumWidth'(acm_pkg::AvgMax)) begin
         b3_avg_in = acm_pkg::MvWidth'(acm_pkg::AvgMax);
      end else begin
         b3_avg_in = b3_avg_full[acm_pkg::MvWidth-1:0];
      end
   end

   // auto-zero capture and deviation
   always_comb begin
      zero_ref_in = zero_ref_ff;
      if (b3_valid_ff && advance && (zero_ref_ff == '0)) begin
         zero_ref_in = b3_avg_ff;
      end
      if (b3_avg_ff >= zero_ref_in) begin
         b4_diff_in = b3_avg_ff - zero_ref_in;
      end else begin
         b4_diff_in = zero_ref_in - b3_avg_ff;
      end
   end

   // current, saturation, deadband
   always_comb begin
      cur_full = acm_pkg::CurFullWidth'(b4_diff_ff) * acm_pkg::CurFullWidth'(acm_pkg::MaPerMv);
      if (cur_full > acm_pkg::CurFullWidth'(acm_pkg::CurrentMax)) begin
         cur_sat = acm_pkg::CurrentWidth'(acm_pkg::CurrentMax);
      end else begin
         cur_sat = cur_full[acm_pkg::CurrentWidth-1:0];
      end
      cur_final = (cur_sat < acm_pkg::CurrentWidth'(acm_pkg::DeadbandMa)) ? '0 : cur_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         b4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         zero_ref_ff  <= '0;
      end else begin
         if (advance) begin
            b1_valid_ff  <= head.valid;
            b2_valid_ff  <= b1_valid_ff;
            b3_valid_ff  <= b2_valid_ff;
            b4_valid_ff  <= b3_valid_ff;
            rsp_valid_ff <= b4_valid_ff;
         end
         zero_ref_ff <= zero_ref_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_sum_ff      <= head.sum;
         b1_prod_ff     <= b1_prod_in;
         b2_sum_ff      <= b1_sum_ff;
         b2_quot_ff     <= b2_quot_in;
         b2_qmul_ff     <= b2_qmul_in;
         b3_avg_ff      <= b3_avg_in;
         b4_avg_ff      <= b3_avg_ff;
         b4_ref_ff      <= zero_ref_in;
         b4_diff_ff     <= b4_diff_in;
         rsp_current_ff <= cur_final;
         rsp_over_ff    <= (cur_final >= threshold);
         rsp_avg_ff     <= b4_avg_ff;
         rsp_ref_ff     <= b4_ref_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign current_ma   = rsp_current_ff;
   assign over_limit   = rsp_over_ff;
   assign average_mv   = rsp_avg_ff;
   assign reference_mv = rsp_ref_ff;

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int unsigned GroupSize   = 10;
   localparam int unsigned DrainCycles = 40;
   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned LongHold    = 400;
   localparam int unsigned HoldAfter   = 60;

   typedef struct packed {
      logic [acm_pkg::MvWidth-1:0]      reference_mv;
      logic [acm_pkg::MvWidth-1:0]      average_mv;
      logic                             over_limit;
      logic [acm_pkg::CurrentWidth-1:0] current_ma;
   } monitor_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // adc_sample [11:0], zero fill above
   logic [acm_pkg::ReqDataWidth-1:0] req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // current_ma [15:0], over_limit [16], average_mv [28:17], reference_mv [40:29]
   logic [acm_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                             csr_psel    = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite  = 1'b0;
   logic [acm_pkg::CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [acm_pkg::CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [acm_pkg::CsrDataWidth-1:0] csr_prdata;
   logic                             csr_pready;

   logic [acm_pkg::AdcWidth-1:0] adc_backlog[$];
   monitor_result_type           pending_results[$];
   int unsigned                  samples_queued = 0;
   int unsigned                  samples_taken  = 0;
   int unsigned                  error_count    = 0;
   int unsigned                  cycle_count    = 0;
   logic                         quiet          = 1'b0;

   // predictor state
   logic [acm_pkg::ThresholdWidth-1:0] alert_threshold =
      acm_pkg::ThresholdWidth'(acm_pkg::ThresholdReset);
   logic [acm_pkg::SumWidth-1:0]       mv_sum          = '0;
   int unsigned                        group_fill      = 0;
   int unsigned                        zero_ref        = 0;

   int unsigned send_gap   = 0;
   int unsigned stall_left = 0;
   logic        hold_done  = 1'b0;

   averaged_current_monitor #(
      .SAMPLES_PER_RESULT(GroupSize)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic flag_error(input string what, input int unsigned want,
                             input int unsigned got);
      error_count++;
      if (error_count <= 10)
         $display("tb: mismatch %s expected %0d got %0d", what, want, got);
   endtask

   task automatic predict_group_result(input logic [acm_pkg::AdcWidth-1:0] sample);
      int unsigned        mv;
      int unsigned        avg;
      int unsigned        diff;
      int unsigned        cur;
      monitor_result_type res;
      mv = (int'(sample) * acm_pkg::MvFullScale) / acm_pkg::AdcFullCode;
      mv_sum = mv_sum + acm_pkg::SumWidth'(mv);
      group_fill++;
      if (group_fill < GroupSize)
         return;
      avg = int'(mv_sum) / GroupSize;
      if (avg > acm_pkg::AvgMax)
         avg = acm_pkg::AvgMax;
      group_fill = 0;
      mv_sum = '0;
      if (zero_ref == 0)
         zero_ref = avg;
      diff = (avg >= zero_ref) ? avg - zero_ref : zero_ref - avg;
      cur = (diff * acm_pkg::MaPerMvNum) / acm_pkg::MaPerMvDen;
      if (cur > acm_pkg::CurrentMax)
         cur = acm_pkg::CurrentMax;
      if (cur < acm_pkg::DeadbandMa)
         cur = 0;
      res.current_ma   = acm_pkg::CurrentWidth'(cur);
      res.over_limit   = (cur >= int'(alert_threshold));
      res.average_mv   = acm_pkg::MvWidth'(avg);
      res.reference_mv = acm_pkg::MvWidth'(zero_ref);
      pending_results.push_back(res);
   endtask

   task automatic queue_sample(input logic [acm_pkg::AdcWidth-1:0] sample);
      adc_backlog.push_back(sample);
      samples_queued++;
   endtask

   task automatic queue_random(input int unsigned count);
      int unsigned mode;
      int          center;
      int          v;
      mode = 0;
      center = 2048;
      for (int unsigned k = 0; k < count; k++) begin
         if (k % GroupSize == 0) begin
            mode = $urandom_range(0, 9);
            if (mode < 2)
               center = 2048 + int'($urandom_range(0, 20)) - 10;
            else
               center = 2048 + int'($urandom_range(0, 2400)) - 1200;
         end
         if (mode < 2)
            v = center + int'($urandom_range(0, 4)) - 2;
         else if (mode < 6)
            v = center + int'($urandom_range(0, 40)) - 20;
         else if (mode < 8)
            v = int'($urandom_range(0, 4095));
         else begin
            v = (center > 2048) ? 4095 : 0;
            if ($urandom_range(0, 3) == 0)
               v = v ^ (1 << $urandom_range(0, 11));
         end
         if (v < 0)
            v = 0;
         if (v > 4095)
            v = 4095;
         queue_sample(acm_pkg::AdcWidth'(v));
      end
   endtask

   task automatic read_threshold(input logic [acm_pkg::ThresholdWidth-1:0] want);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= acm_pkg::CsrAddrWidth'(acm_pkg::CsrThresholdIndex * 4);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata != acm_pkg::CsrDataWidth'(want))
         flag_error("threshold readback", 32'(want), csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_threshold(input logic [acm_pkg::ThresholdWidth-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= acm_pkg::CsrAddrWidth'(acm_pkg::CsrThresholdIndex * 4);
      csr_pwdata  <= acm_pkg::CsrDataWidth'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      alert_threshold = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      read_threshold(value);
   endtask

   task automatic wait_idle();
      while (samples_taken != samples_queued || pending_results.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!quiet && adc_backlog.size() != 0 && $urandom_range(0, 11) == 0) begin
            send_gap   <= $urandom_range(0, 16);
            req_tvalid <= 1'b0;
         end else if (adc_backlog.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= acm_pkg::ReqDataWidth'(adc_backlog.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // request monitor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_group_result(req_tdata[acm_pkg::AdcWidth-1:0]);
         samples_taken <= samples_taken + 1;
      end
   end

   // response ready with stalls and one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         hold_done  <= 1'b0;
      end else if (!hold_done && samples_taken >= HoldAfter) begin
         hold_done  <= 1'b1;
         stall_left <= LongHold;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // response check
   always @(posedge clock) begin : rsp_check
      monitor_result_type got;
      monitor_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[acm_pkg::RspUsedWidth-1:0];
         if (pending_results.size() == 0) begin
            flag_error("unexpected response current_ma", 0, 32'(got.current_ma));
         end else begin
            want = pending_results.pop_front();
            if (got.current_ma != want.current_ma)
               flag_error("current_ma", 32'(want.current_ma), 32'(got.current_ma));
            if (got.over_limit != want.over_limit)
               flag_error("over_limit", 32'(want.over_limit), 32'(got.over_limit));
            if (got.average_mv != want.average_mv)
               flag_error("average_mv", 32'(want.average_mv), 32'(got.average_mv));
            if (got.reference_mv != want.reference_mv)
               flag_error("reference_mv", 32'(want.reference_mv), 32'(got.reference_mv));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      read_threshold(acm_pkg::ThresholdWidth'(acm_pkg::ThresholdReset));

      // zero-average group keeps the reference open
      for (int k = 0; k < 10; k++)
         queue_sample(acm_pkg::AdcWidth'(k % 2));
      // capture group, average 1650 mv
      for (int k = 0; k < 10; k++)
         queue_sample((k % 2 == 0) ? 12'hAAA : 12'h555);
      for (int k = 0; k < 5; k++)
         queue_sample(12'hFFF);
      wait_idle();

      write_threshold(16'd500);
      queue_random(200);
      wait_idle();
      write_threshold(16'd50000);
      queue_random(50);
      wait_idle();
      write_threshold(16'd0);
      queue_random(50);
      wait_idle();
      write_threshold(16'hFFFF);
      queue_random(50);
      wait_idle();
      write_threshold(acm_pkg::ThresholdWidth'(acm_pkg::MaPerMv * $urandom_range(7, 625)));
      queue_random(50);
      wait_idle();
      write_threshold(acm_pkg::ThresholdWidth'($urandom_range(500, 50000)));
      queue_random(50);
      wait_idle();
      write_threshold(acm_pkg::ThresholdWidth'(acm_pkg::ThresholdReset));
      quiet = 1'b1;
      queue_random(50);
      wait_idle();

      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/acm_pkg.sv
hw/rtl/acm_front.sv
hw/rtl/acm_queue.sv
hw/rtl/acm_back.sv
hw/rtl/averaged_current_monitor.sv
dv/tb.sv
